FILE: rtl/tmc_pkg.sv
// Shared types and constants for the one-minute candle builder.
package tmc_pkg;

  localparam int unsigned RING_MINUTES  = 60;
  localparam int unsigned SLOT_W        = (RING_MINUTES > 1) ? $clog2(RING_MINUTES) : 1;
  localparam int unsigned MINUTE_MS     = 60 * 1000;
  localparam int unsigned TIME_W        = 47;
  localparam int unsigned PRICE_W       = 32;
  localparam int unsigned QTY_W         = 32;
  localparam int unsigned MINUTE_W      = 32;
  localparam int unsigned VOL_W         = 48;

  typedef enum logic [1:0] {
    EV_SAME  = 2'd0,
    EV_ROLL  = 2'd1,
    EV_MERGE = 2'd2,
    EV_DROP  = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    K_PASS = 2'd0,
    K_ROLL = 2'd1,
    K_LATE = 2'd2
  } tick_kind_t;

  typedef struct packed {
    logic [MINUTE_W-1:0] minute;
    logic [SLOT_W-1:0]   slot;
    logic [PRICE_W-1:0]  price;
    logic [QTY_W-1:0]    qty;
  } tick_t;

  typedef struct packed {
    logic [MINUTE_W-1:0] minute;
    logic [PRICE_W-1:0]  open;
    logic [PRICE_W-1:0]  high;
    logic [PRICE_W-1:0]  low;
    logic [PRICE_W-1:0]  close;
    logic [VOL_W-1:0]    volume;
  } bar_t;

endpackage

FILE: rtl/tmc_minute_div.sv
// Pipelined division of the timestamp by one minute, with the ring slot of the quotient.
module tmc_minute_div import tmc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [TIME_W-1:0]   in_time_ms,
  input  logic [PRICE_W-1:0]  in_price,
  input  logic [QTY_W-1:0]    in_qty,
  output logic                out_valid,
  output tick_t               out_tick
);

  localparam int unsigned REM_W       = $clog2(MINUTE_MS);
  localparam int unsigned LOW_W       = MINUTE_W;
  localparam int unsigned STEPS       = 4;
  localparam int unsigned STAGES      = MINUTE_W / STEPS;
  localparam logic [REM_W:0]  DIVISOR = (REM_W + 1)'(MINUTE_MS);
  localparam logic [SLOT_W:0] RING_C  = (SLOT_W + 1)'(RING_MINUTES);

  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [LOW_W-1:0]    low;
    logic [MINUTE_W-1:0] quo;
    logic [SLOT_W-1:0]   slot;
    logic [PRICE_W-1:0]  price;
    logic [QTY_W-1:0]    qty;
  } div_st_t;

  function automatic div_st_t div_steps(input div_st_t s);
    div_st_t           r;
    logic [REM_W:0]    t;
    logic [SLOT_W:0]   m;
    logic              ge;
    r = s;
    for (int i = 0; i < STEPS; i++) begin
      t     = {r.rem, r.low[LOW_W-1]};
      r.low = {r.low[LOW_W-2:0], 1'b0};
      ge    = (t >= DIVISOR);
      r.rem = ge ? REM_W'(t - DIVISOR) : t[REM_W-1:0];
      r.quo = {r.quo[MINUTE_W-2:0], ge};
      m     = {r.slot, ge};
      r.slot = (m >= RING_C) ? SLOT_W'(m - RING_C) : m[SLOT_W-1:0];
    end
    return r;
  endfunction

  div_st_t st_r [STAGES];
  logic    v_r  [STAGES];
  div_st_t head;

  always_comb begin
    head       = '0;
    head.rem   = REM_W'(in_time_ms[TIME_W-1:LOW_W]);
    head.low   = in_time_ms[LOW_W-1:0];
    head.price = in_price;
    head.qty   = in_qty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STAGES; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < STAGES; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= div_steps(head);
      for (int k = 1; k < STAGES; k++) st_r[k] <= div_steps(st_r[k-1]);
    end
  end

  assign out_valid       = v_r[STAGES-1];
  assign out_tick.minute = st_r[STAGES-1].quo;
  assign out_tick.slot   = st_r[STAGES-1].slot;
  assign out_tick.price  = st_r[STAGES-1].price;
  assign out_tick.qty    = st_r[STAGES-1].qty;

endmodule

FILE: rtl/tick_to_minute_candle.sv
// Top level of the one-minute OHLCV candle builder with a ring of finished candles.
// Takes one tick per cycle while the output is not stalled and returns exactly
// one result per tick, in order. The pipelined division of the timestamp by 60000
// (four quotient bits per stage, the ring slot is built alongside) feeds the
// classify stage, which checks the tick against the working candle held in
// registers and issues the ring read. The merge stage writes a finished candle to
// the ring on a rollover or merges a late tick into its entry, and registers the
// result. Ring writes are forwarded to a same-slot read issued in the same cycle.
// A stall on the output freezes the whole pipeline; no reset sweep is needed.
module tick_to_minute_candle import tmc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TIME_W-1:0]    in_time_ms,
  input  logic [PRICE_W-1:0]   in_price,
  input  logic [QTY_W-1:0]     in_qty,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_event_res,
  output logic [MINUTE_W-1:0]  out_bar_minute,
  output logic [PRICE_W-1:0]   out_bar_open,
  output logic [PRICE_W-1:0]   out_bar_high,
  output logic [PRICE_W-1:0]   out_bar_low,
  output logic [PRICE_W-1:0]   out_bar_close,
  output logic [VOL_W-1:0]     out_bar_volume
);

  function automatic bar_t bar_start(input tick_t t);
    bar_t b;
    b.minute = t.minute;
    b.open   = t.price;
    b.high   = t.price;
    b.low    = t.price;
    b.close  = t.price;
    b.volume = VOL_W'(t.qty);
    return b;
  endfunction

  function automatic bar_t bar_fold(input bar_t b, input logic [PRICE_W-1:0] p,
                                    input logic [QTY_W-1:0] q);
    bar_t         r;
    logic [VOL_W:0] s;
    r       = b;
    s       = {1'b0, b.volume} + (VOL_W + 1)'(q);
    r.high  = (p > b.high) ? p : b.high;
    r.low   = (p < b.low) ? p : b.low;
    r.close = p;
    r.volume = s[VOL_W] ? {VOL_W{1'b1}} : s[VOL_W-1:0];
    return r;
  endfunction

  logic  en;
  logic  dv_valid;
  tick_t dv_tick;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  tmc_minute_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_time_ms (in_time_ms),
    .in_price   (in_price),
    .in_qty     (in_qty),
    .out_valid  (dv_valid),
    .out_tick   (dv_tick)
  );

  // working candle and classify stage
  logic              have_working_r, have_working_nxt;
  bar_t              work_r, work_nxt;
  logic [SLOT_W-1:0] work_slot_r, work_slot_nxt;
  tick_kind_t        r_kind;
  bar_t              r_bar;
  logic [SLOT_W-1:0] r_slot;

  always_comb begin
    have_working_nxt = have_working_r;
    work_nxt         = work_r;
    work_slot_nxt    = work_slot_r;
    r_kind           = K_PASS;
    r_bar            = work_r;
    r_slot           = dv_tick.slot;
    if (!have_working_r) begin
      have_working_nxt = 1'b1;
      work_nxt         = bar_start(dv_tick);
      work_slot_nxt    = dv_tick.slot;
      r_bar            = work_nxt;
    end else if (dv_tick.minute == work_r.minute) begin
      work_nxt = bar_fold(work_r, dv_tick.price, dv_tick.qty);
      r_bar    = work_nxt;
    end else if (dv_tick.minute > work_r.minute) begin
      r_kind        = K_ROLL;
      r_slot        = work_slot_r;
      work_nxt      = bar_start(dv_tick);
      work_slot_nxt = dv_tick.slot;
    end else begin
      r_kind = K_LATE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_working_r <= 1'b0;
    end else if (en && dv_valid) begin
      have_working_r <= have_working_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && dv_valid) begin
      work_r      <= work_nxt;
      work_slot_r <= work_slot_nxt;
    end
  end

  // ring memory and merge stage
  bar_t                  ring_mem [RING_MINUTES];
  logic [RING_MINUTES-1:0] slot_valid_r;
  bar_t                  rd_bar_r;

  logic                  m_valid_r;
  tick_kind_t            m_kind_r;
  bar_t                  m_bar_r;
  logic [SLOT_W-1:0]     m_slot_r;
  logic [MINUTE_W-1:0]   m_minute_r;
  logic [PRICE_W-1:0]    m_price_r;
  logic [QTY_W-1:0]      m_qty_r;
  logic                  m_vld_r;
  logic                  fwd_hit_r;
  bar_t                  fwd_bar_r;

  bar_t                  row;
  bar_t                  merged;
  logic                  hit;
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_slot;
  bar_t                  wr_bar;
  event_t                ev;
  bar_t                  ev_bar;
  logic                  fwd_hit;

  always_comb begin
    row     = fwd_hit_r ? fwd_bar_r : rd_bar_r;
    hit     = m_vld_r && (row.minute == m_minute_r);
    merged  = bar_fold(row, m_price_r, m_qty_r);
    wr_en   = 1'b0;
    wr_slot = m_slot_r;
    wr_bar  = m_bar_r;
    ev      = EV_SAME;
    ev_bar  = m_bar_r;
    unique case (m_kind_r)
      K_PASS: begin
        ev = EV_SAME;
      end
      K_ROLL: begin
        ev    = EV_ROLL;
        wr_en = en && m_valid_r;
      end
      K_LATE: begin
        if (hit) begin
          ev     = EV_MERGE;
          ev_bar = merged;
          wr_bar = merged;
          wr_en  = en && m_valid_r;
        end else begin
          ev            = EV_DROP;
          ev_bar        = '0;
          ev_bar.minute = m_minute_r;
        end
      end
      default: begin
        ev = EV_SAME;
      end
    endcase
  end

  assign fwd_hit = wr_en && (wr_slot == dv_tick.slot);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_slot] <= wr_bar;
    end
    if (en && dv_valid && r_kind == K_LATE) begin
      rd_bar_r <= ring_mem[dv_tick.slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (wr_en) begin
      slot_valid_r[wr_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_kind_r   <= r_kind;
      m_bar_r    <= r_bar;
      m_slot_r   <= r_slot;
      m_minute_r <= dv_tick.minute;
      m_price_r  <= dv_tick.price;
      m_qty_r    <= dv_tick.qty;
      m_vld_r    <= slot_valid_r[dv_tick.slot] || fwd_hit;
      fwd_hit_r  <= fwd_hit;
      fwd_bar_r  <= wr_bar;
    end
  end

  // output register
  logic    out_valid_r;
  event_t  out_ev_r;
  bar_t    out_bar_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ev_r  <= ev;
      out_bar_r <= ev_bar;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = out_ev_r;
  assign out_bar_minute = out_bar_r.minute;
  assign out_bar_open   = out_bar_r.open;
  assign out_bar_high   = out_bar_r.high;
  assign out_bar_low    = out_bar_r.low;
  assign out_bar_close  = out_bar_r.close;
  assign out_bar_volume = out_bar_r.volume;

  a_write_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> slot_valid_r[$past(wr_slot)])
    else $error("ring write did not mark its slot valid");

  a_forward_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (m_valid_r && m_kind_r == K_LATE && fwd_hit_r) |-> m_vld_r)
    else $error("forwarded ring row not seen as valid");

  a_roll_needs_working: assert property (@(posedge clk) disable iff (!rst_n)
    (m_valid_r && m_kind_r == K_ROLL) |-> have_working_r)
    else $error("rollover without a working candle");

  a_merge_is_late: assert property (@(posedge clk) disable iff (!rst_n)
    (m_valid_r && (ev == EV_MERGE || ev == EV_DROP)) |-> (m_kind_r == K_LATE))
    else $error("late event from a tick that was not late");

endmodule

FILE: bench/tick_to_minute_candle_test.sv
// Self-checking testbench for the one-minute candle builder with its ring of finished candles.
module tick_to_minute_candle_test import tmc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    event_t ev;
    bar_t   bar;
  } candle_t;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  class candle_tracker;
    bit      have_working;
    bar_t    working;
    bit      slot_used[RING_MINUTES];
    bar_t    ring[RING_MINUTES];
    candle_t pending_candles[$];
    int      seen[4];
    int      errors;
    int      checked;

    function bar_t open_candle(logic [MINUTE_W-1:0] minute, logic [PRICE_W-1:0] p,
                               logic [QTY_W-1:0] q);
      bar_t b;
      b.minute = minute;
      b.open   = p;
      b.high   = p;
      b.low    = p;
      b.close  = p;
      b.volume = {16'b0, q};
      return b;
    endfunction

    function bar_t fold_price(bar_t b, logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q);
      logic [VOL_W:0] sum;
      if (p > b.high) b.high = p;
      if (p < b.low) b.low = p;
      b.close = p;
      sum = {1'b0, b.volume} + {17'b0, q};
      b.volume = sum[VOL_W] ? '1 : sum[VOL_W-1:0];
      return b;
    endfunction

    function int outstanding();
      return pending_candles.size();
    endfunction

    function void note_tick(logic [TIME_W-1:0] t, logic [PRICE_W-1:0] p,
                            logic [QTY_W-1:0] q);
      logic [63:0]         minute64;
      logic [MINUTE_W-1:0] minute;
      int unsigned         s;
      candle_t             c;
      minute64 = 64'(t) / 64'(MINUTE_MS);
      minute = minute64[MINUTE_W-1:0];
      if (!have_working) begin
        have_working = 1'b1;
        working = open_candle(minute, p, q);
        c.ev = EV_SAME;
        c.bar = working;
      end else if (minute == working.minute) begin
        working = fold_price(working, p, q);
        c.ev = EV_SAME;
        c.bar = working;
      end else if (minute > working.minute) begin
        s = working.minute % RING_MINUTES;
        ring[s] = working;
        slot_used[s] = 1'b1;
        c.ev = EV_ROLL;
        c.bar = working;
        working = open_candle(minute, p, q);
      end else begin
        s = minute % RING_MINUTES;
        if (slot_used[s] && ring[s].minute == minute) begin
          ring[s] = fold_price(ring[s], p, q);
          c.ev = EV_MERGE;
          c.bar = ring[s];
        end else begin
          c.ev = EV_DROP;
          c.bar = '0;
          c.bar.minute = minute;
        end
      end
      pending_candles.push_back(c);
      seen[c.ev]++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("MISMATCH: %0s", msg);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want,
                       logic [MINUTE_W-1:0] minute);
      if (got !== want)
        report($sformatf("minute %0d %0s got %h want %h", minute, name, got, want));
    endtask

    task check_candle(candle_t got);
      candle_t want;
      if (pending_candles.size() == 0) begin
        report("result arrived with no tick outstanding");
        return;
      end
      want = pending_candles.pop_front();
      checked++;
      compare_field("event", got.ev, want.ev, want.bar.minute);
      compare_field("minute", got.bar.minute, want.bar.minute, want.bar.minute);
      compare_field("open", got.bar.open, want.bar.open, want.bar.minute);
      compare_field("high", got.bar.high, want.bar.high, want.bar.minute);
      compare_field("low", got.bar.low, want.bar.low, want.bar.minute);
      compare_field("close", got.bar.close, want.bar.close, want.bar.minute);
      compare_field("volume", got.bar.volume, want.bar.volume, want.bar.minute);
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [TIME_W-1:0]   in_time_ms;
  logic [PRICE_W-1:0]  in_price;
  logic [QTY_W-1:0]    in_qty;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          out_event_res;
  logic [MINUTE_W-1:0] out_bar_minute;
  logic [PRICE_W-1:0]  out_bar_open;
  logic [PRICE_W-1:0]  out_bar_high;
  logic [PRICE_W-1:0]  out_bar_low;
  logic [PRICE_W-1:0]  out_bar_close;
  logic [VOL_W-1:0]    out_bar_volume;

  candle_tracker ledger = new;
  int unsigned   burst_left;
  bit            gaps_on;

  tick_to_minute_candle u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_time_ms     (in_time_ms),
    .in_price       (in_price),
    .in_qty         (in_qty),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_res  (out_event_res),
    .out_bar_minute (out_bar_minute),
    .out_bar_open   (out_bar_open),
    .out_bar_high   (out_bar_high),
    .out_bar_low    (out_bar_low),
    .out_bar_close  (out_bar_close),
    .out_bar_volume (out_bar_volume)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [TIME_W-1:0] at_minute(logic [63:0] m, int unsigned off);
    return TIME_W'(m * MINUTE_MS + off);
  endfunction

  task automatic send_tick(input logic [TIME_W-1:0] t, input logic [PRICE_W-1:0] p,
                           input logic [QTY_W-1:0] q);
    in_valid   <= 1'b1;
    in_time_ms <= t;
    in_price   <= p;
    in_qty     <= q;
    do @(posedge clk); while (in_stall);
    ledger.note_tick(t, p, q);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
    end
  endtask

  task automatic hold_until_drained();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (ledger.outstanding() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    candle_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.ev         = event_t'(out_event_res);
      got.bar.minute = out_bar_minute;
      got.bar.open   = out_bar_open;
      got.bar.high   = out_bar_high;
      got.bar.low    = out_bar_low;
      got.bar.close  = out_bar_close;
      got.bar.volume = out_bar_volume;
      ledger.check_candle(got);
    end
  end

  initial begin
    stall_mode_t mode;
    int unsigned span;
    int unsigned k;
    wait (rst_n === 1'b1);
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= (k % 5 < 2);
        endcase
      end
    end
  end

  initial begin
    int unsigned        i;
    int unsigned        pick;
    int unsigned        back;
    int unsigned        off;
    logic [63:0]        wm;
    logic [63:0]        mnt;
    logic [63:0]        top_minute;
    logic [TIME_W-1:0]  t;
    logic [PRICE_W-1:0] p;
    logic [PRICE_W-1:0] last_price;
    logic [QTY_W-1:0]   q;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_time_ms = '0;
    in_price   = '0;
    in_qty     = '0;
    out_stall  = 1'b0;
    burst_left = 0;
    gaps_on    = 1'b1;
    last_price = 32'd150000;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_tick(at_minute(0, 0), 32'd1000, 32'd0);
    send_tick(at_minute(0, 59999), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_tick(at_minute(0, 30000), 32'd0, 32'd7);
    send_tick(at_minute(1, 0), 32'd12345, 32'd3);
    send_tick(at_minute(0, 100), 32'd2, 32'd9);
    send_tick(at_minute(1, 500), 32'd12000, 32'd4);
    send_tick(at_minute(3, 1), 32'd13000, 32'd5);
    send_tick(at_minute(2, 42), 32'd14000, 32'd6);
    send_tick(at_minute(1, 900), 32'd99999, 32'd8);
    send_tick(at_minute(61, 10), 32'd20000, 32'd10);
    send_tick(at_minute(62, 20), 32'd21000, 32'd11);
    send_tick(at_minute(1, 300), 32'd22000, 32'd12);
    send_tick(at_minute(61, 400), 32'd19000, 32'd13);
    send_tick(at_minute(0, 200), 32'd5, 32'd14);
    send_tick(at_minute(62, 59999), 32'hFFFF_FFFF, 32'd15);
    send_tick(at_minute(119, 0), 32'd30000, 32'd16);
    send_tick(at_minute(59, 777), 32'd31000, 32'd17);
    hold_until_drained();

    for (i = 0; i < 40; i++)
      send_tick(at_minute(200, i % 60000), $urandom, 32'hFFFF_FFFF);
    send_tick(at_minute(201, 7), 32'd500, 32'd1);
    send_tick(at_minute(200, 100), 32'd9, 32'hFFFF_FFFF);
    hold_until_drained();

    send_tick(at_minute($urandom_range(1000, 2000000000), $urandom_range(0, 59999)),
              $urandom, $urandom);
    for (i = 0; i < 350; i++) begin
      if (i == 200) hold_until_drained();
      gaps_on = !(i >= 100 && i < 160);
      wm = ledger.working.minute;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) off = $urandom_range(0, 1) ? 0 : 59999;
      else off = $urandom_range(0, 59999);
      if (pick < 50) begin
        t = at_minute(wm, off);
      end else if (pick < 70) begin
        t = at_minute(wm + $urandom_range(1, 3), off);
      end else if (pick < 74) begin
        t = at_minute(wm + $urandom_range(55, 130), off);
      end else if (pick < 94) begin
        back = $urandom_range(1, 70);
        mnt = (wm >= back) ? wm - back : 64'd0;
        t = at_minute(mnt, off);
      end else begin
        t = TIME_W'({$urandom, $urandom} % (wm * MINUTE_MS));
      end
      case ($urandom_range(0, 9))
        0:          p = '0;
        1:          p = '1;
        2, 3, 4, 5: p = last_price + $urandom_range(0, 400) - 200;
        default:    p = $urandom;
      endcase
      last_price = p;
      case ($urandom_range(0, 9))
        0:       q = '0;
        1:       q = '1;
        2, 3:    q = $urandom;
        default: q = $urandom_range(1, 5000);
      endcase
      send_tick(t, p, q);
    end

    gaps_on = 1'b1;
    t = '1;
    top_minute = 64'(t) / 64'(MINUTE_MS);
    send_tick(t, $urandom, $urandom);
    send_tick(at_minute(top_minute - 1, 5), $urandom, $urandom);
    send_tick(at_minute(top_minute, 0), $urandom, $urandom);

    hold_until_drained();
    repeat (30) @(negedge clk);
    if (ledger.outstanding() != 0)
      ledger.report($sformatf("%0d expected candles never came", ledger.outstanding()));

    $display("ticks driven: same minute %0d, rollover %0d, late merged %0d, late dropped %0d",
             ledger.seen[EV_SAME], ledger.seen[EV_ROLL], ledger.seen[EV_MERGE],
             ledger.seen[EV_DROP]);
    $display("large volumes, ring slot reuse and full-range timestamps run; %0d compared",
             ledger.checked);
    if (ledger.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
